[rtl/trajectory_window_motion_estimator_top_assert.svh]
// assertion macros for the trajectory window motion estimator top level
// relies on i_clk and i_rst_n being visible at the point of use
`ifndef TRAJECTORY_WINDOW_MOTION_ESTIMATOR_TOP_ASSERT_SVH
`define TRAJECTORY_WINDOW_MOTION_ESTIMATOR_TOP_ASSERT_SVH

// same-cycle implication, quiet during reset
`define TWME_CHECK(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, quiet during reset
`define TWME_CHECK_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/twme_pkg.sv]
// shared constants, types and the arctangent table of the motion estimator
// no dependencies
`default_nettype none

package twme_pkg;

    localparam int WINDOW_DEPTH_DEF = 10;

    localparam int POS_W   = 32;
    localparam int DIFF_W  = 33;
    localparam int SQ_W    = 66;
    localparam int LEN_W   = 33;
    localparam int SUM_W   = 40;
    localparam int DREM_W  = 34;
    localparam int DNUM_W  = 48;
    localparam int QUOT_W  = 40;
    localparam int DCNT_W  = 6;
    localparam int ACC_W   = 22;
    localparam int CORD_W  = 32;
    localparam int Z_W     = 17;
    localparam int HEAD_W  = 16;
    localparam int MEAN_W  = 32;
    localparam int PTS_W   = 4;
    localparam int UQ_W    = 15;

    localparam int UNIT_ONE    = 16384;
    localparam int HALF_PI_Q13 = 12868;
    localparam int PI_Q13      = 25736;
    localparam int CORD_ITERS  = 14;
    localparam int SQRT_ITERS  = 33;
    localparam int UNIT_STEPS  = 15;
    localparam int MEAN_STEPS  = 40;

    // request word into the shared divider
    typedef struct packed {
        logic              start;
        logic [DREM_W-1:0] rem;
        logic [DNUM_W-1:0] num;
        logic [DREM_W-1:0] div;
        logic [DCNT_W-1:0] steps;
    } t_div_req;

    // round(atan(2^-i) * 8192)
    function automatic logic signed [Z_W-1:0] atan_q13(input logic [3:0] idx);
        logic signed [Z_W-1:0] v;
        v = '0;
        unique case (idx)
            4'd0:    v = 17'sd6434;
            4'd1:    v = 17'sd3798;
            4'd2:    v = 17'sd2007;
            4'd3:    v = 17'sd1019;
            4'd4:    v = 17'sd511;
            4'd5:    v = 17'sd256;
            4'd6:    v = 17'sd128;
            4'd7:    v = 17'sd64;
            4'd8:    v = 17'sd32;
            4'd9:    v = 17'sd16;
            4'd10:   v = 17'sd8;
            4'd11:   v = 17'sd4;
            4'd12:   v = 17'sd2;
            4'd13:   v = 17'sd1;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

[rtl/twme_intf.sv]
// valid/ready channel interfaces for position words in and motion words out
// depends on twme_pkg
`default_nettype none

interface twme_in_if
    import twme_pkg::*;
;
    logic                    valid;
    logic                    ready;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic                    found;

    modport source (output valid, pos_x, pos_y, found, input ready);
    modport sink   (input valid, pos_x, pos_y, found, output ready);
endinterface

interface twme_out_if
    import twme_pkg::*;
;
    logic                     valid;
    logic                     ready;
    logic [MEAN_W-1:0]        mean_step;
    logic signed [HEAD_W-1:0] heading;
    logic [PTS_W-1:0]         points_held;

    modport source (output valid, mean_step, heading, points_held, input ready);
    modport sink   (input valid, mean_step, heading, points_held, output ready);
endinterface

`default_nettype wire

[rtl/twme_div.sv]
// shared restoring divider, one quotient bit per cycle
// depends on twme_pkg
`default_nettype none

module twme_div
    import twme_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_div_req          i_req,
    output logic                   o_done,
    output logic [QUOT_W-1:0]      o_quot
);

    logic              r_busy;
    logic              r_done;
    logic [DCNT_W-1:0] r_cnt;
    logic [DREM_W-1:0] r_rem;
    logic [DNUM_W-1:0] r_sh;
    logic [DREM_W-1:0] r_div;
    logic [QUOT_W-1:0] r_q;

    logic [DREM_W:0]   n_trial;
    logic              n_fit;

    // shift in the next numerator bit and try the subtraction
    always_comb begin
        n_trial = {r_rem, r_sh[DNUM_W-1]};
        n_fit   = (n_trial >= {1'b0, r_div});
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_req.steps;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == DCNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= i_req.rem;
            r_sh  <= i_req.num;
            r_div <= i_req.div;
            r_q   <= '0;
        end else if (r_busy) begin
            r_sh <= {r_sh[DNUM_W-2:0], 1'b0};
            if (n_fit) begin
                r_rem <= DREM_W'(n_trial - {1'b0, r_div});
                r_q   <= {r_q[QUOT_W-2:0], 1'b1};
            end else begin
                r_rem <= n_trial[DREM_W-1:0];
                r_q   <= {r_q[QUOT_W-2:0], 1'b0};
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule

`default_nettype wire

[rtl/twme_sqrt.sv]
// digit-by-digit integer square root of a 66-bit sum of squares
// depends on twme_pkg
`default_nettype none

module twme_sqrt
    import twme_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [SQ_W-1:0]  i_val,
    output logic                  o_done,
    output logic [LEN_W-1:0]      o_root
);

    localparam int REM_W = 38;

    logic              r_busy;
    logic              r_done;
    logic [5:0]        r_cnt;
    logic [SQ_W-1:0]   r_val;
    logic [REM_W-1:0]  r_rem;
    logic [LEN_W-1:0]  r_root;

    logic [REM_W-1:0]  n_pull;
    logic [REM_W-1:0]  n_trial;

    // bring down two bits and form the trial subtrahend
    always_comb begin
        n_pull  = {r_rem[REM_W-3:0], r_val[SQ_W-1:SQ_W-2]};
        n_trial = REM_W'({r_root, 2'b01});
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 6'(SQRT_ITERS);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == 6'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_val  <= i_val;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_val <= {r_val[SQ_W-3:0], 2'b00};
            if (n_pull >= n_trial) begin
                r_rem  <= n_pull - n_trial;
                r_root <= {r_root[LEN_W-2:0], 1'b1};
            end else begin
                r_rem  <= n_pull;
                r_root <= {r_root[LEN_W-2:0], 1'b0};
            end
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

`default_nettype wire

[rtl/twme_cordic.sv]
// vectoring cordic giving atan2 in radians q3.13, one iteration per cycle
// depends on twme_pkg
`default_nettype none

module twme_cordic
    import twme_pkg::*;
(
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_start,
    input  wire logic signed [CORD_W-1:0] i_x,
    input  wire logic signed [CORD_W-1:0] i_y,
    output logic                          o_done,
    output logic signed [HEAD_W-1:0]      o_heading
);

    logic                     r_busy;
    logic                     r_done;
    logic [3:0]               r_i;
    logic signed [CORD_W-1:0] r_x;
    logic signed [CORD_W-1:0] r_y;
    logic signed [Z_W-1:0]    r_z;

    logic signed [CORD_W-1:0] n_xs;
    logic signed [CORD_W-1:0] n_ys;
    logic signed [Z_W-1:0]    n_ang;
    logic signed [HEAD_W-1:0] n_clamp;

    // shared shifter, angle lookup and output clamp
    always_comb begin
        n_xs  = r_x >>> r_i;
        n_ys  = r_y >>> r_i;
        n_ang = atan_q13(r_i);
        if (r_z > Z_W'(PI_Q13)) begin
            n_clamp = HEAD_W'(PI_Q13);
        end else if (r_z < -Z_W'(PI_Q13)) begin
            n_clamp = -HEAD_W'(PI_Q13);
        end else begin
            n_clamp = r_z[HEAD_W-1:0];
        end
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_i    <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_i <= '0;
                if (i_x == '0 && i_y == '0) begin
                    r_done <= 1'b1;
                end else begin
                    r_busy <= 1'b1;
                end
            end else if (r_busy) begin
                r_i <= r_i + 1'b1;
                if (r_i == 4'(CORD_ITERS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // quarter-turn pre-rotation for the left half-plane, then micro-rotations
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            if (i_x == '0 && i_y == '0) begin
                r_x <= '0;
                r_y <= '0;
                r_z <= '0;
            end else if (i_x < 0) begin
                if (i_y >= 0) begin
                    r_x <= i_y;
                    r_y <= -i_x;
                    r_z <= Z_W'(HALF_PI_Q13);
                end else begin
                    r_x <= -i_y;
                    r_y <= i_x;
                    r_z <= -Z_W'(HALF_PI_Q13);
                end
            end else begin
                r_x <= i_x;
                r_y <= i_y;
                r_z <= '0;
            end
        end else if (r_busy) begin
            if (r_y > 0) begin
                r_x <= r_x + n_ys;
                r_y <= r_y - n_xs;
                r_z <= r_z + n_ang;
            end else begin
                r_x <= r_x - n_ys;
                r_y <= r_y + n_xs;
                r_z <= r_z - n_ang;
            end
        end
    end

    assign o_done    = r_done;
    assign o_heading = n_clamp;

endmodule

`default_nettype wire

[rtl/trajectory_window_motion_estimator_top.sv]
// channel     dir  payload                                  handshake
// i_in        in   pos_x s32, pos_y s32, found 1            valid/ready
// o_out       out  mean_step u32, heading s16, points_held 4 valid/ready
//
// one word at a time: a new word is taken only once the result of the last one has
// been handed to the output register; each step runs the square root and two 15-bit
// divides, the divides skipped for a zero-length step, then a 40-bit mean divide and
// a 14-step cordic follow, the cordic finishing at once when the summed directions
// cancel; one or no points go straight to the output
// the window sits in a register-read memory, read one point per step
// sync active-low reset clears counts and control; window contents are not cleared
// a finished result waits in the output register while the next word is taken
// depends on twme_pkg, twme_intf, twme_div, twme_sqrt, twme_cordic
`default_nettype none

module trajectory_window_motion_estimator_top
    import twme_pkg::*;
#(
    parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    twme_in_if.sink    i_in,
    twme_out_if.source o_out
);

    localparam int SLOT_W = $clog2(WINDOW_DEPTH);
    localparam int CNT_W  = $clog2(WINDOW_DEPTH + 1);
    localparam logic [CNT_W:0]    DEPTH_E   = (CNT_W+1)'(WINDOW_DEPTH);
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(WINDOW_DEPTH - 1);

    localparam logic [4:0] S_IDLE   = 5'd0;
    localparam logic [4:0] S_START  = 5'd1;
    localparam logic [4:0] S_WAIT1  = 5'd2;
    localparam logic [4:0] S_FIRST  = 5'd3;
    localparam logic [4:0] S_WAIT   = 5'd4;
    localparam logic [4:0] S_DIFF   = 5'd5;
    localparam logic [4:0] S_MULX   = 5'd6;
    localparam logic [4:0] S_MULY   = 5'd7;
    localparam logic [4:0] S_SQ_GO  = 5'd8;
    localparam logic [4:0] S_SQ_WT  = 5'd9;
    localparam logic [4:0] S_DX_GO  = 5'd10;
    localparam logic [4:0] S_DX_WT  = 5'd11;
    localparam logic [4:0] S_DY_GO  = 5'd12;
    localparam logic [4:0] S_DY_WT  = 5'd13;
    localparam logic [4:0] S_NEXT   = 5'd14;
    localparam logic [4:0] S_MN_GO  = 5'd15;
    localparam logic [4:0] S_MN_WT  = 5'd16;
    localparam logic [4:0] S_CR_GO  = 5'd17;
    localparam logic [4:0] S_CR_WT  = 5'd18;
    localparam logic [4:0] S_DONE   = 5'd19;

    logic [4:0]              r_state;
    logic [CNT_W-1:0]        r_fill;
    logic [SLOT_W-1:0]       r_oldest;
    logic [SLOT_W-1:0]       r_rd_addr;
    logic [CNT_W-1:0]        r_step;

    logic signed [POS_W-1:0] r_mem_x [WINDOW_DEPTH];
    logic signed [POS_W-1:0] r_mem_y [WINDOW_DEPTH];
    logic signed [POS_W-1:0] r_rd_x;
    logic signed [POS_W-1:0] r_rd_y;
    logic signed [POS_W-1:0] r_prev_x;
    logic signed [POS_W-1:0] r_prev_y;

    logic [DIFF_W-1:0]       r_ax;
    logic [DIFF_W-1:0]       r_ay;
    logic                    r_negx;
    logic                    r_negy;
    logic [SQ_W-1:0]         r_sq;
    logic [LEN_W-1:0]        r_len;
    logic [SUM_W-1:0]        r_sum;
    logic signed [ACC_W-1:0] r_sx;
    logic signed [ACC_W-1:0] r_sy;
    logic [MEAN_W-1:0]       r_mean;
    logic signed [HEAD_W-1:0] r_head;

    logic                     r_out_valid;
    logic [MEAN_W-1:0]        r_out_mean;
    logic signed [HEAD_W-1:0] r_out_head;
    logic [PTS_W-1:0]         r_out_pts;

    logic                    n_in_acc;
    logic [CNT_W:0]          n_wsum;
    logic [SLOT_W-1:0]       n_wslot;
    logic [SLOT_W-1:0]       n_oldest_inc;
    logic [SLOT_W-1:0]       n_addr_inc;
    logic signed [DIFF_W-1:0] n_dx;
    logic signed [DIFF_W-1:0] n_dy;
    logic [DIFF_W-1:0]       n_mul_op;
    logic [SQ_W-1:0]         n_mul_p;
    logic [DNUM_W-1:0]       n_unum;
    logic [UQ_W-1:0]         n_ucap;
    logic signed [ACC_W-1:0] n_uval;
    logic signed [CORD_W-1:0] n_cx;
    logic signed [CORD_W-1:0] n_cy;
    logic [7:0]              n_fill8;

    t_div_req                n_div_req;
    logic                    w_div_done;
    logic [QUOT_W-1:0]       w_quot;
    logic                    w_sq_done;
    logic [LEN_W-1:0]        w_root;
    logic                    w_cr_done;
    logic signed [HEAD_W-1:0] w_heading;

    // handshake and slot arithmetic
    always_comb begin
        n_in_acc     = i_in.valid && (r_state == S_IDLE);
        n_wsum       = (CNT_W+1)'(r_oldest) + (CNT_W+1)'(r_fill);
        n_wslot      = (n_wsum >= DEPTH_E) ? SLOT_W'(n_wsum - DEPTH_E) : SLOT_W'(n_wsum);
        n_oldest_inc = (r_oldest == LAST_SLOT) ? '0 : r_oldest + 1'b1;
        n_addr_inc   = (r_rd_addr == LAST_SLOT) ? '0 : r_rd_addr + 1'b1;
    end

    // step vector, shared squarer and unit-direction helpers
    always_comb begin
        n_dx     = DIFF_W'(r_rd_x) - DIFF_W'(r_prev_x);
        n_dy     = DIFF_W'(r_rd_y) - DIFF_W'(r_prev_y);
        n_mul_op = (r_state == S_MULX) ? r_ax : r_ay;
        n_mul_p  = SQ_W'(n_mul_op * n_mul_op);
        n_unum   = DNUM_W'({((r_state == S_DX_GO) ? r_ax : r_ay), 14'b0})
                   + DNUM_W'(r_len[LEN_W-1:1]);
        n_ucap   = (w_quot[UQ_W-1:0] > UQ_W'(UNIT_ONE)) ? UQ_W'(UNIT_ONE)
                                                         : w_quot[UQ_W-1:0];
        n_uval   = ACC_W'(n_ucap);
        n_cx     = CORD_W'(r_sx) <<< 8;
        n_cy     = CORD_W'(r_sy) <<< 8;
        n_fill8  = 8'(r_fill);
    end

    // divider requests: unit components and the final mean
    always_comb begin
        n_div_req       = '0;
        n_div_req.start = (r_state == S_DX_GO) || (r_state == S_DY_GO)
                          || (r_state == S_MN_GO);
        if (r_state == S_MN_GO) begin
            n_div_req.rem   = '0;
            n_div_req.num   = {r_sum, 8'b0};
            n_div_req.div   = DREM_W'(r_fill);
            n_div_req.steps = DCNT_W'(MEAN_STEPS);
        end else begin
            n_div_req.rem   = DREM_W'(n_unum[DNUM_W-1:UNIT_STEPS]);
            n_div_req.num   = {n_unum[UNIT_STEPS-1:0], (DNUM_W-UNIT_STEPS)'(0)};
            n_div_req.div   = DREM_W'(r_len);
            n_div_req.steps = DCNT_W'(UNIT_STEPS);
        end
    end

    twme_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (n_div_req),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    twme_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == S_SQ_GO),
        .i_val   (r_sq),
        .o_done  (w_sq_done),
        .o_root  (w_root)
    );

    twme_cordic u_cordic (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (r_state == S_CR_GO),
        .i_x       (n_cx),
        .i_y       (n_cy),
        .o_done    (w_cr_done),
        .o_heading (w_heading)
    );

    // window memory, registered read
    always_ff @(posedge i_clk) begin
        if (n_in_acc && i_in.found) begin
            r_mem_x[n_wslot] <= i_in.pos_x;
            r_mem_y[n_wslot] <= i_in.pos_y;
        end
        r_rd_x <= r_mem_x[r_rd_addr];
        r_rd_y <= r_mem_y[r_rd_addr];
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fill      <= '0;
            r_oldest    <= '0;
            r_rd_addr   <= '0;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // output register empties when read, unless a new word lands this cycle
            if (o_out.ready && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (n_in_acc) begin
                        if (i_in.found) begin
                            if (r_fill < CNT_W'(WINDOW_DEPTH)) begin
                                r_fill <= r_fill + 1'b1;
                            end else begin
                                r_oldest <= n_oldest_inc;
                            end
                        end
                        r_state <= S_START;
                    end
                end
                S_START: begin
                    r_rd_addr <= r_oldest;
                    r_state   <= (r_fill < CNT_W'(2)) ? S_DONE : S_WAIT1;
                end
                S_WAIT1: r_state <= S_FIRST;
                S_FIRST: begin
                    r_rd_addr <= n_addr_inc;
                    r_step    <= CNT_W'(1);
                    r_state   <= S_WAIT;
                end
                S_WAIT:  r_state <= S_DIFF;
                S_DIFF:  r_state <= S_MULX;
                S_MULX:  r_state <= S_MULY;
                S_MULY:  r_state <= S_SQ_GO;
                S_SQ_GO: r_state <= S_SQ_WT;
                S_SQ_WT: begin
                    if (w_sq_done) begin
                        r_state <= (w_root == '0) ? S_NEXT : S_DX_GO;
                    end
                end
                S_DX_GO: r_state <= S_DX_WT;
                S_DX_WT: begin
                    if (w_div_done) begin
                        r_state <= S_DY_GO;
                    end
                end
                S_DY_GO: r_state <= S_DY_WT;
                S_DY_WT: begin
                    if (w_div_done) begin
                        r_state <= S_NEXT;
                    end
                end
                S_NEXT: begin
                    if ((CNT_W+1)'(r_step) + 1'b1 == (CNT_W+1)'(r_fill)) begin
                        r_state <= S_MN_GO;
                    end else begin
                        r_step    <= r_step + 1'b1;
                        r_rd_addr <= n_addr_inc;
                        r_state   <= S_WAIT;
                    end
                end
                S_MN_GO: r_state <= S_MN_WT;
                S_MN_WT: begin
                    if (w_div_done) begin
                        r_state <= S_CR_GO;
                    end
                end
                S_CR_GO: r_state <= S_CR_WT;
                S_CR_WT: begin
                    if (w_cr_done) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (!r_out_valid || o_out.ready) begin
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // step datapath and result collection
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_START: begin
                r_sum  <= '0;
                r_sx   <= '0;
                r_sy   <= '0;
                r_mean <= '0;
                r_head <= '0;
            end
            S_FIRST: begin
                r_prev_x <= r_rd_x;
                r_prev_y <= r_rd_y;
            end
            S_DIFF: begin
                r_ax     <= n_dx[DIFF_W-1] ? DIFF_W'(-n_dx) : DIFF_W'(n_dx);
                r_ay     <= n_dy[DIFF_W-1] ? DIFF_W'(-n_dy) : DIFF_W'(n_dy);
                r_negx   <= n_dx[DIFF_W-1];
                r_negy   <= n_dy[DIFF_W-1];
                r_prev_x <= r_rd_x;
                r_prev_y <= r_rd_y;
            end
            S_MULX: r_sq <= n_mul_p;
            S_MULY: r_sq <= r_sq + n_mul_p;
            S_SQ_WT: begin
                if (w_sq_done) begin
                    r_len <= w_root;
                    r_sum <= r_sum + SUM_W'(w_root);
                    // zero-length step points along +x
                    if (w_root == '0) begin
                        r_sx <= r_sx + ACC_W'(UNIT_ONE);
                    end
                end
            end
            S_DX_WT: begin
                if (w_div_done) begin
                    r_sx <= r_negx ? r_sx - n_uval : r_sx + n_uval;
                end
            end
            S_DY_WT: begin
                if (w_div_done) begin
                    r_sy <= r_negy ? r_sy - n_uval : r_sy + n_uval;
                end
            end
            S_MN_WT: begin
                if (w_div_done) begin
                    r_mean <= (w_quot[QUOT_W-1:MEAN_W] != '0) ? '1 : w_quot[MEAN_W-1:0];
                end
            end
            S_CR_WT: begin
                if (w_cr_done) begin
                    r_head <= w_heading;
                end
            end
            S_DONE: begin
                if (!r_out_valid || o_out.ready) begin
                    r_out_mean <= r_mean;
                    r_out_head <= r_head;
                    r_out_pts  <= n_fill8[PTS_W-1:0];
                end
            end
            default: ;
        endcase
    end

    assign i_in.ready        = (r_state == S_IDLE);
    assign o_out.valid       = r_out_valid;
    assign o_out.mean_step   = r_out_mean;
    assign o_out.heading     = r_out_head;
    assign o_out.points_held = r_out_pts;

`include "trajectory_window_motion_estimator_top_assert.svh"

    `TWME_CHECK(a_fill_bound, 1'b1, r_fill <= CNT_W'(WINDOW_DEPTH), "fill count past depth")
    `TWME_CHECK(a_oldest_bound, 1'b1, r_oldest <= LAST_SLOT, "oldest slot out of range")
    `TWME_CHECK(a_step_bound, r_state == S_DIFF, r_step < r_fill, "step index past held points")
    `TWME_CHECK_NEXT(a_busy_after_take, n_in_acc, !i_in.ready, "input taken while busy")
    `TWME_CHECK(a_heading_range, r_out_valid,
        (r_out_head <= HEAD_W'(PI_Q13)) && (r_out_head >= -HEAD_W'(PI_Q13)),
        "heading outside half turn")

endmodule

`default_nettype wire

[tb/sv/testbench.sv]
`timescale 1ns / 1ps
// self-checking bench for trajectory_window_motion_estimator_top
// depends on twme_pkg, twme_intf and the top level with its submodules
`default_nettype none

module testbench;
    import twme_pkg::*;

    localparam int DEPTH      = 10;
    localparam int IDLE_LIMIT = 40000;
    localparam int NUM_RANDOM = 630;

    typedef struct {
        logic [MEAN_W-1:0]        mean_step;
        logic signed [HEAD_W-1:0] heading;
        logic [PTS_W-1:0]         points_held;
    } t_motion;

    // scoreboard: window model plus the queue of pending motion words
    class motion_board;
        longint   win_x [DEPTH];
        longint   win_y [DEPTH];
        int       held;
        int       head_slot;
        t_motion  pending [$];
        int       errors;

        function void clear();
            held = 0;
            head_slot = 0;
            errors = 0;
            pending.delete();
        endfunction

        // exact floor square root of a 66-bit value
        function longint root66(logic [65:0] v);
            logic [67:0] rem;
            logic [67:0] trial;
            longint      root;
            root = 0;
            rem = '0;
            for (int k = 32; k >= 0; k--) begin
                rem = (rem << 2) | v[2*k +: 2];
                trial = ({4'b0, root} << 2) | 1;
                if (rem >= trial) begin
                    rem = rem - trial;
                    root = (root << 1) | 1;
                end else begin
                    root = root << 1;
                end
            end
            return root;
        endfunction

        function longint unit_part(longint a, bit neg, longint len);
            longint m;
            m = (a * UNIT_ONE + len / 2) / len;
            if (m > UNIT_ONE) m = UNIT_ONE;
            return neg ? -m : m;
        endfunction

        // vectoring cordic with left half-plane pre-rotation
        function longint angle_of(longint x, longint y);
            longint z, nx, ny, xs, ys;
            longint atan_tab [14] = '{6434, 3798, 2007, 1019, 511, 256, 128, 64, 32,
                                      16, 8, 4, 2, 1};
            z = 0;
            if (x == 0 && y == 0) return 0;
            if (x < 0) begin
                if (y >= 0) begin
                    nx = y; ny = -x; z = HALF_PI_Q13;
                end else begin
                    nx = -y; ny = x; z = -HALF_PI_Q13;
                end
                x = nx;
                y = ny;
            end
            for (int i = 0; i < 14; i++) begin
                xs = x >>> i;
                ys = y >>> i;
                if (y > 0) begin
                    nx = x + ys; ny = y - xs; z += atan_tab[i];
                end else begin
                    nx = x - ys; ny = y + xs; z -= atan_tab[i];
                end
                x = nx;
                y = ny;
            end
            if (z > PI_Q13) z = PI_Q13;
            if (z < -PI_Q13) z = -PI_Q13;
            return z;
        endfunction

        // accepted position word: update window, queue expected motion word
        function void note_position(logic signed [31:0] px, logic signed [31:0] py,
                                    logic fnd);
            int          slot;
            longint      cx, cy, lx, ly, dx, dy, ax, ay, len, sum_len, sx, sy, mean;
            logic [65:0] sq;
            t_motion     exp_word;
            if (fnd) begin
                if (held < DEPTH) begin
                    slot = (head_slot + held) % DEPTH;
                    held++;
                end else begin
                    slot = head_slot;
                    head_slot = (head_slot + 1) % DEPTH;
                end
                win_x[slot] = px;
                win_y[slot] = py;
            end
            sum_len = 0; sx = 0; sy = 0; lx = 0; ly = 0;
            for (int i = 0; i < held; i++) begin
                slot = (head_slot + i) % DEPTH;
                cx = win_x[slot];
                cy = win_y[slot];
                if (i > 0) begin
                    dx = cx - lx;
                    dy = cy - ly;
                    ax = dx < 0 ? -dx : dx;
                    ay = dy < 0 ? -dy : dy;
                    sq = 66'(ax) * 66'(ax) + 66'(ay) * 66'(ay);
                    len = root66(sq);
                    sum_len += len;
                    if (len == 0) begin
                        sx += UNIT_ONE;
                    end else begin
                        sx += unit_part(ax, dx < 0, len);
                        sy += unit_part(ay, dy < 0, len);
                    end
                end
                lx = cx;
                ly = cy;
            end
            if (held == 0) begin
                exp_word.mean_step = '0;
                exp_word.heading = '0;
            end else begin
                mean = sum_len / held;
                if (mean > 64'hFFFF_FFFF) mean = 64'hFFFF_FFFF;
                exp_word.mean_step = mean[31:0];
                exp_word.heading = 16'(angle_of(sx * 256, sy * 256));
            end
            exp_word.points_held = 4'(held);
            pending.insert(pending.size(), exp_word);
        endfunction

        function void check_motion(t_motion got);
            t_motion want;
            if (pending.size() == 0) begin
                $display("%0t: unexpected motion word mean %h heading %0d points %0d",
                         $time, got.mean_step, got.heading, got.points_held);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got.mean_step !== want.mean_step) begin
                $display("%0t: mean_step expected %h actual %h", $time,
                         want.mean_step, got.mean_step);
                errors++;
            end
            if (got.heading !== want.heading) begin
                $display("%0t: heading expected %0d actual %0d", $time,
                         want.heading, got.heading);
                errors++;
            end
            if (got.points_held !== want.points_held) begin
                $display("%0t: points_held expected %0d actual %0d", $time,
                         want.points_held, got.points_held);
                errors++;
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    twme_in_if  pos_ch ();
    twme_out_if mot_ch ();

    trajectory_window_motion_estimator_top #(.WINDOW_DEPTH(DEPTH)) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (pos_ch.sink),
        .o_out   (mot_ch.source)
    );

    motion_board board;
    int          idle_cycles;
    int          stall_mode;
    int          stall_phase;
    logic signed [31:0] last_x, last_y;

    initial i_clk = 1'b0;
    always #4 i_clk = ~i_clk;

    // monitor: note accepted words on both channels
    always @(posedge i_clk) begin
        t_motion got;
        if (i_rst_n) begin
            if (pos_ch.valid && pos_ch.ready)
                board.note_position(pos_ch.pos_x, pos_ch.pos_y, pos_ch.found);
            if (mot_ch.valid && mot_ch.ready) begin
                got.mean_step = mot_ch.mean_step;
                got.heading = mot_ch.heading;
                got.points_held = mot_ch.points_held;
                board.check_motion(got);
            end
        end
    end

    // receiver stall pattern, mode picked at random from time to time
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            mot_ch.ready <= 1'b0;
            stall_phase <= 0;
            stall_mode <= 0;
        end else begin
            stall_phase <= stall_phase + 1;
            if (stall_phase % 3000 == 2999) stall_mode <= $urandom_range(0, 3);
            case (stall_mode)
                0: begin
                    mot_ch.ready <= 1'b1;
                end
                1: begin
                    mot_ch.ready <= 1'($urandom_range(0, 1));
                end
                2: begin
                    mot_ch.ready <= (stall_phase % 64) >= 40;
                end
                default: begin
                    mot_ch.ready <= ($urandom_range(0, 9) == 0);
                end
            endcase
        end
    end

    // watchdog on cycles with no accepted word
    always @(posedge i_clk) begin
        if ((pos_ch.valid && pos_ch.ready) || (mot_ch.valid && mot_ch.ready) || !i_rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("trajectory_window_motion_estimator_top verification failed");
            $finish;
        end
    end

    // present one word and hold it until taken
    task automatic send_position(logic signed [31:0] px, logic signed [31:0] py,
                                 logic fnd);
        pos_ch.valid <= 1'b1;
        pos_ch.pos_x <= px;
        pos_ch.pos_y <= py;
        pos_ch.found <= fnd;
        @(posedge i_clk);
        while (!pos_ch.ready) @(posedge i_clk);
        if (fnd) begin
            last_x = px;
            last_y = py;
        end
    endtask

    task automatic pause_sender(int cycles);
        if (cycles > 0) begin
            pos_ch.valid <= 1'b0;
            repeat (cycles) @(posedge i_clk);
        end
    endtask

    // random word: mostly small walks, some wide jumps and skipped frames
    task automatic send_random();
        int                 pick;
        logic signed [31:0] px, py;
        pick = $urandom_range(0, 99);
        if (pick < 15) begin
            send_position($urandom, $urandom, 1'b0);
        end else if (pick < 30) begin
            send_position($urandom, $urandom, 1'b1);
        end else if (pick < 35) begin
            send_position(last_x, last_y, 1'b1);
        end else begin
            px = last_x + $signed(32'($urandom_range(0, 1 << 21)) - 32'(1 << 20));
            py = last_y + $signed(32'($urandom_range(0, 1 << 21)) - 32'(1 << 20));
            if ($urandom_range(0, 4) == 0) py = last_y;
            if ($urandom_range(0, 4) == 0) px = last_x;
            send_position(px, py, 1'b1);
        end
    endtask

    localparam logic signed [31:0] POS_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] POS_MIN = 32'sh8000_0000;

    initial begin
        int sent;
        int burst;
        int drain;
        board = new();
        board.clear();
        last_x = 0;
        last_y = 0;
        i_rst_n = 1'b0;
        pos_ch.valid = 1'b0;
        pos_ch.pos_x = '0;
        pos_ch.pos_y = '0;
        pos_ch.found = 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty window, single point, zero-length step
        send_position(32'sh1234_5678, -32'sd99, 1'b0);
        send_position(32'sd0, 32'sd0, 1'b1);
        send_position(32'sd0, 32'sd0, 1'b0);
        send_position(32'sd0, 32'sd0, 1'b1);
        // left half-plane headings, above and below the axis
        send_position(-32'sd65536, 32'sd100, 1'b1);
        send_position(-32'sd131072, -32'sd70000, 1'b1);
        send_position(-32'sd131072, 32'sd500000, 1'b1);
        pause_sender(3);
        // extreme diagonal swings fill and wrap the window, mean saturates
        for (int i = 0; i < 12; i++) begin
            if (i % 2 == 0) send_position(POS_MIN, POS_MIN, 1'b1);
            else send_position(POS_MAX, POS_MAX, 1'b1);
        end
        send_position(POS_MAX, POS_MIN, 1'b1);
        send_position(POS_MIN, POS_MAX, 1'b0);
        send_position(32'sd1, -32'sd1, 1'b1);

        // random bursts with random gaps
        sent = 0;
        while (sent < NUM_RANDOM) begin
            burst = $urandom_range(1, 20);
            for (int i = 0; i < burst && sent < NUM_RANDOM; i++) begin
                send_random();
                sent++;
            end
            if ($urandom_range(0, 2) != 0) pause_sender($urandom_range(1, 12));
        end
        pos_ch.valid <= 1'b0;

        // drain and settle
        drain = 0;
        while (board.pending.size() != 0 && drain < 200000) begin
            @(posedge i_clk);
            drain++;
        end
        repeat (1000) @(posedge i_clk);
        if (board.errors == 0 && board.pending.size() == 0)
            $display("trajectory_window_motion_estimator_top verification clean");
        else
            $display("trajectory_window_motion_estimator_top verification failed");
        $finish;
    end

endmodule

`default_nettype wire
